// File: rtl/core/sha256d_header_tail_hash_top_defines.svh
// Assertion helpers for the double-hash core.
`ifndef SHA256D_HEADER_TAIL_HASH_TOP_DEFINES_SVH
`define SHA256D_HEADER_TAIL_HASH_TOP_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define SHD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define SHD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/shd_pkg.sv
package shd_pkg;

    typedef struct packed {
        logic [31:0] tail_word_0;
        logic [31:0] tail_word_1;
        logic [31:0] tail_word_2;
        logic [31:0] tail_word_3;
    } in_t;

    typedef struct packed {
        logic [31:0] digest_word_0;
        logic [31:0] digest_word_1;
        logic [31:0] digest_word_2;
        logic [31:0] digest_word_3;
        logic [31:0] digest_word_4;
        logic [31:0] digest_word_5;
        logic [31:0] digest_word_6;
        logic [31:0] digest_word_7;
    } out_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_PASS1  = 5'b00010,
        ST_RESEED = 5'b00100,
        ST_PASS2  = 5'b01000,
        ST_FINAL  = 5'b10000
    } state_t;

    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_MID_PAIR_0 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MID_PAIR_1 = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MID_PAIR_2 = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MID_PAIR_3 = 4'd3;

    localparam logic [5:0]  LAST_ROUND = 6'd63;
    localparam logic [31:0] PAD_WORD   = 32'h8000_0000;
    localparam logic [31:0] LEN_TAIL   = 32'h0000_0280;  // 640-bit message
    localparam logic [31:0] LEN_DIGEST = 32'h0000_0100;  // 256-bit message

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] sml_sig0(input logic [31:0] x);
        sml_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sml_sig1(input logic [31:0] x);
        sml_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// File: rtl/core/sha256d_header_tail_hash_top.sv
// Channel | Dir | Handshake           | Payload
// in      | in  | in_valid/in_ready   | in_data  (shd_pkg::in_t, four tail words)
// out     | out | out_valid/out_ready | out_data (shd_pkg::out_t, eight digest words)
// cfg     | in  | cfg_valid/cfg_ready | cfg_index, cfg_data (midstate word pairs)
//
// A request runs through the accept, the rounds from the midstate, a reseed step,
// the rounds from the initial values and a final add. The rounds of both passes use
// the single shared round unit, one round per cycle.
// Reset clears the midstate to zero and returns the sequencer to idle.
// A finished digest waits in the output register; a new request is accepted
// meanwhile, but the final add stalls until the output register is free.
`include "sha256d_header_tail_hash_top_defines.svh"

module sha256d_header_tail_hash_top
    import shd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_t                  in_data,

    output logic                 out_valid,
    input  logic                 out_ready,
    output out_t                 out_data,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data
);

    state_t      state_reg, state_next;
    logic [5:0]  round_reg, round_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] mid_pair_reg [4];
    logic [63:0] mid_pair_next [4];

    logic [31:0] w_reg [16];
    logic [31:0] w_next [16];
    logic [31:0] v_reg [8];
    logic [31:0] v_next [8];
    out_t        out_data_reg, out_data_next;

    logic [31:0] mid_word [8];
    logic [31:0] sum_word [8];
    logic [31:0] t1, t2, w_new;
    logic        out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Shared round unit; the schedule is a shift line with fixed taps.
    always_comb
    begin
        t1 = v_reg[7] + big_sig1(v_reg[4])
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + ROUND_K[round_reg] + w_reg[0];
        t2 = big_sig0(v_reg[0])
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        w_new = sml_sig1(w_reg[14]) + w_reg[9] + sml_sig0(w_reg[1]) + w_reg[0];
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            mid_word[2*i]   = mid_pair_reg[i][63:32];
            mid_word[2*i+1] = mid_pair_reg[i][31:0];
        end
        // Chain add: midstate in the reseed cycle, initial values at the end.
        for (int i = 0; i < 8; i++)
        begin
            sum_word[i] = ((state_reg == ST_RESEED) ? mid_word[i] : INIT_H[i]) + v_reg[i];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        round_next     = round_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mid_pair_next  = mid_pair_reg;
        w_next         = w_reg;
        v_next         = v_reg;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MID_PAIR_0: mid_pair_next[0] = cfg_data;
                CFG_MID_PAIR_1: mid_pair_next[1] = cfg_data;
                CFG_MID_PAIR_2: mid_pair_next[2] = cfg_data;
                CFG_MID_PAIR_3: mid_pair_next[3] = cfg_data;
                default: ;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    for (int i = 0; i < 16; i++)
                    begin
                        w_next[i] = '0;
                    end
                    w_next[0]  = in_data.tail_word_0;
                    w_next[1]  = in_data.tail_word_1;
                    w_next[2]  = in_data.tail_word_2;
                    w_next[3]  = in_data.tail_word_3;
                    w_next[4]  = PAD_WORD;
                    w_next[15] = LEN_TAIL;
                    v_next     = mid_word;
                    round_next = '0;
                    state_next = ST_PASS1;
                end
            end
            ST_PASS1, ST_PASS2:
            begin
                for (int i = 0; i < 15; i++)
                begin
                    w_next[i] = w_reg[i+1];
                end
                w_next[15] = w_new;
                v_next[7]  = v_reg[6];
                v_next[6]  = v_reg[5];
                v_next[5]  = v_reg[4];
                v_next[4]  = v_reg[3] + t1;
                v_next[3]  = v_reg[2];
                v_next[2]  = v_reg[1];
                v_next[1]  = v_reg[0];
                v_next[0]  = t1 + t2;
                round_next = round_reg + 6'd1;
                if (round_reg == LAST_ROUND)
                begin
                    state_next = (state_reg == ST_PASS1) ? ST_RESEED : ST_FINAL;
                end
            end
            ST_RESEED:
            begin
                // First digest becomes the single padded block of pass two.
                for (int i = 0; i < 16; i++)
                begin
                    w_next[i] = '0;
                end
                for (int i = 0; i < 8; i++)
                begin
                    w_next[i] = sum_word[i];
                end
                w_next[8]  = PAD_WORD;
                w_next[15] = LEN_DIGEST;
                v_next     = INIT_H;
                round_next = '0;
                state_next = ST_PASS2;
            end
            ST_FINAL:
            begin
                if (out_free)
                begin
                    out_data_next.digest_word_0 = sum_word[0];
                    out_data_next.digest_word_1 = sum_word[1];
                    out_data_next.digest_word_2 = sum_word[2];
                    out_data_next.digest_word_3 = sum_word[3];
                    out_data_next.digest_word_4 = sum_word[4];
                    out_data_next.digest_word_5 = sum_word[5];
                    out_data_next.digest_word_6 = sum_word[6];
                    out_data_next.digest_word_7 = sum_word[7];
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                mid_pair_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
            mid_pair_reg  <= mid_pair_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg        <= w_next;
        v_reg        <= v_next;
        out_data_reg <= out_data_next;
    end

    `SHD_ASSERT_NEXT(a_accept_starts_pass1, in_valid && in_ready,
        state_reg == ST_PASS1 && round_reg == 6'd0, "accept did not start pass one")
    `SHD_ASSERT_NEXT(a_pass1_to_reseed, state_reg == ST_PASS1 && round_reg == LAST_ROUND,
        state_reg == ST_RESEED, "pass one did not hand over to reseed")
    `SHD_ASSERT_NOW(a_round_only_in_pass, round_reg != 6'd0,
        state_reg == ST_PASS1 || state_reg == ST_PASS2, "round count live outside a pass")
    `SHD_ASSERT_NEXT(a_final_loads_output, state_reg == ST_FINAL && out_free,
        out_valid_reg && state_reg == ST_IDLE, "final add did not load the output")

endmodule
